// ----- hdl/chip8_instruction_executor_assert.svh -----
// assertion macros for the chip8 instruction executor
// no dependencies; included by c8x_ctrl, which checks its own logic
`ifndef CHIP8_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define C8_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define C8_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define C8_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define C8_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/c8x_pkg.sv -----
// shared types, constants and font table for the chip8 instruction executor
// no dependencies
package c8x_pkg;

  localparam int unsigned RamBytesDef     = 4096;
  localparam int unsigned StackDepthDef   = 16;
  localparam int unsigned ProgramStartDef = 512;
  localparam int unsigned FontBytes       = 80;

  // datapath command codes
  typedef enum logic [3:0] {
    CMD_NONE    = 4'd0,
    CMD_LOAD    = 4'd1,
    CMD_EXEC    = 4'd2,
    CMD_BCD     = 4'd3,
    CMD_STORE   = 4'd4,
    CMD_LDADDR  = 4'd5,
    CMD_LDDATA  = 4'd6,
    CMD_FONT    = 4'd7
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [3:0] step;
  } ctl_t;

  typedef struct packed {
    logic [3:0] x;
    logic       is_bcd;
    logic       is_store;
    logic       is_load;
    logic       is_load_act;
  } sts_t;

  function automatic logic [7:0] font_byte(input logic [6:0] a);
    logic [7:0] f;
    begin
      case (a)
        7'd0: f = 8'hF0; 7'd1: f = 8'h90; 7'd2: f = 8'h90; 7'd3: f = 8'h90;
        7'd4: f = 8'hF0; 7'd5: f = 8'h20; 7'd6: f = 8'h60; 7'd7: f = 8'h20;
        7'd8: f = 8'h20; 7'd9: f = 8'h70; 7'd10: f = 8'hF0; 7'd11: f = 8'h10;
        7'd12: f = 8'hF0; 7'd13: f = 8'h80; 7'd14: f = 8'hF0; 7'd15: f = 8'hF0;
        7'd16: f = 8'h10; 7'd17: f = 8'hF0; 7'd18: f = 8'h10; 7'd19: f = 8'hF0;
        7'd20: f = 8'h90; 7'd21: f = 8'h90; 7'd22: f = 8'hF0; 7'd23: f = 8'h10;
        7'd24: f = 8'h10; 7'd25: f = 8'hF0; 7'd26: f = 8'h80; 7'd27: f = 8'hF0;
        7'd28: f = 8'h10; 7'd29: f = 8'hF0; 7'd30: f = 8'hF0; 7'd31: f = 8'h80;
        7'd32: f = 8'hF0; 7'd33: f = 8'h90; 7'd34: f = 8'hF0; 7'd35: f = 8'hF0;
        7'd36: f = 8'h10; 7'd37: f = 8'h20; 7'd38: f = 8'h40; 7'd39: f = 8'h40;
        7'd40: f = 8'hF0; 7'd41: f = 8'h90; 7'd42: f = 8'hF0; 7'd43: f = 8'h90;
        7'd44: f = 8'hF0; 7'd45: f = 8'hF0; 7'd46: f = 8'h90; 7'd47: f = 8'hF0;
        7'd48: f = 8'h10; 7'd49: f = 8'hF0; 7'd50: f = 8'hF0; 7'd51: f = 8'h90;
        7'd52: f = 8'hF0; 7'd53: f = 8'h90; 7'd54: f = 8'h90; 7'd55: f = 8'hE0;
        7'd56: f = 8'h90; 7'd57: f = 8'hE0; 7'd58: f = 8'h90; 7'd59: f = 8'hE0;
        7'd60: f = 8'hF0; 7'd61: f = 8'h80; 7'd62: f = 8'h80; 7'd63: f = 8'h80;
        7'd64: f = 8'hF0; 7'd65: f = 8'hE0; 7'd66: f = 8'h90; 7'd67: f = 8'h90;
        7'd68: f = 8'h90; 7'd69: f = 8'hE0; 7'd70: f = 8'hF0; 7'd71: f = 8'h80;
        7'd72: f = 8'hF0; 7'd73: f = 8'h80; 7'd74: f = 8'hF0; 7'd75: f = 8'hF0;
        7'd76: f = 8'h80; 7'd77: f = 8'hF0; 7'd78: f = 8'h80; 7'd79: f = 8'h80;
        default: f = 8'h00;
      endcase
      return f;
    end
  endfunction

endpackage

// ----- hdl/chip8_instruction_executor.sv -----
// top level of the chip8 instruction executor
// depends on c8x_pkg, c8x_ctrl, c8x_dpath and c8x_ram
//
//   channel | signals                      | direction
//   input   | in_valid_i, in_stall_o, ...  | item in
//   output  | out_valid_o, out_stall_i,... | result out
//
// after acceptance most opcodes pass S_OUT and S_DONE before the next word can be
// taken; Fx33 and Fx55 first write ram in S_MULTI and Fx65 alternates S_LDA and
// S_LDD per register, set by the single ram port (read is registered).
// after reset a pass writes the 80 font bytes into ram, with in_stall_o high.
// one word is in flight; a stalled result holds and no new word is taken.
module chip8_instruction_executor import c8x_pkg::*; #(
  parameter int unsigned RAM_BYTES     = RamBytesDef,
  parameter int unsigned STACK_DEPTH   = StackDepthDef,
  parameter int unsigned PROGRAM_START = ProgramStartDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [15:0] opcode_i,
  input  logic [7:0]  random_byte_i,
  input  logic [15:0] keys_pressed_i,
  input  logic [11:0] load_offset_i,
  input  logic [7:0]  load_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] pc_value_o,
  output logic [15:0] index_value_o,
  output logic [7:0]  delay_value_o,
  output logic [7:0]  sound_value_o,
  output logic        clear_request_o,
  output logic        draw_request_o,
  output logic [7:0]  draw_x_o,
  output logic [7:0]  draw_y_o,
  output logic [3:0]  draw_rows_o,
  output logic        unknown_opcode_o,
  output logic        stack_fault_o
);
  ctl_t ctl;
  sts_t sts;

  c8x_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  c8x_dpath #(
    .RamBytes(RAM_BYTES), .StackDepth(STACK_DEPTH), .ProgramStart(PROGRAM_START)
  ) u_dpath (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts),
    .action_i, .opcode_i, .random_byte_i, .keys_pressed_i, .load_offset_i,
    .load_data_i, .pc_value_o, .index_value_o, .delay_value_o,
    .sound_value_o, .clear_request_o, .draw_request_o, .draw_x_o, .draw_y_o,
    .draw_rows_o, .unknown_opcode_o, .stack_fault_o
  );
endmodule

// ----- hdl/c8x_ram.sv -----
// generic single port ram with registered read
// no dependencies
module c8x_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // read before write, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- hdl/c8x_ctrl.sv -----
// sequencer for the chip8 instruction executor
// depends on c8x_pkg
`include "chip8_instruction_executor_assert.svh"
module c8x_ctrl import c8x_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output ctl_t ctl_o
);
  typedef enum logic [6:0] {
    S_FONT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MULTI = 7'b0000100,
    S_LDA   = 7'b0001000,
    S_LDD   = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic [6:0] cnt_q, cnt_d;
  logic [3:0] x_q, x_d;
  logic       bcd_q, bcd_d, st_q, st_d;
  logic       accept;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // next state and command
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    x_d     = x_q;
    bcd_d   = bcd_q;
    st_d    = st_q;
    ctl_o   = '{cmd: CMD_NONE, step: cnt_q[3:0]};
    case (state_q)
      S_FONT: begin
        ctl_o.cmd = CMD_FONT;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(FontBytes - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cnt_d = '0;
          x_d   = sts_i.x;
          bcd_d = sts_i.is_bcd;
          st_d  = sts_i.is_store;
          if (sts_i.is_load_act) begin
            ctl_o.cmd = CMD_LOAD;
            state_d = S_OUT;
          end else begin
            ctl_o.cmd = CMD_EXEC;
            if (sts_i.is_bcd || sts_i.is_store) state_d = S_MULTI;
            else if (sts_i.is_load) state_d = S_LDA;
            else state_d = S_OUT;
          end
        end
      end
      S_MULTI: begin
        ctl_o.cmd = bcd_q ? CMD_BCD : CMD_STORE;
        cnt_d = cnt_q + 7'd1;
        if ((bcd_q && cnt_q == 7'd2) || (!bcd_q && cnt_q[3:0] == x_q)) state_d = S_OUT;
      end
      S_LDA: begin
        ctl_o.cmd = CMD_LDADDR;
        state_d = S_LDD;
      end
      S_LDD: begin
        ctl_o.cmd = CMD_LDDATA;
        if (cnt_q[3:0] == x_q) state_d = S_OUT;
        else begin
          cnt_d = cnt_q + 7'd1;
          state_d = S_LDA;
        end
      end
      S_OUT: state_d = S_DONE;
      S_DONE: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = (state_q == S_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FONT;
      cnt_q   <= '0;
      x_q     <= '0;
      bcd_q   <= 1'b0;
      st_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      x_q     <= x_d;
      bcd_q   <= bcd_d;
      st_q    <= st_d;
    end
  end

  `C8_ASSERT_IMP(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `C8_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `C8_ASSERT_IMP(a_noacc, clk_i, rst_ni, out_valid_o, in_stall_o)
  `C8_ASSERT_IMP(a_cnt, clk_i, rst_ni, state_q == S_MULTI && bcd_q, cnt_q < 7'd3)
endmodule

// ----- hdl/c8x_dpath.sv -----
// registers, stack, alu and ram of the chip8 instruction executor
// depends on c8x_pkg and c8x_ram
module c8x_dpath import c8x_pkg::*; #(
  parameter int unsigned RamBytes     = RamBytesDef,
  parameter int unsigned StackDepth   = StackDepthDef,
  parameter int unsigned ProgramStart = ProgramStartDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_t        ctl_i,
  output sts_t        sts_o,
  input  logic        action_i,
  input  logic [15:0] opcode_i,
  input  logic [7:0]  random_byte_i,
  input  logic [15:0] keys_pressed_i,
  input  logic [11:0] load_offset_i,
  input  logic [7:0]  load_data_i,
  output logic [11:0] pc_value_o,
  output logic [15:0] index_value_o,
  output logic [7:0]  delay_value_o,
  output logic [7:0]  sound_value_o,
  output logic        clear_request_o,
  output logic        draw_request_o,
  output logic [7:0]  draw_x_o,
  output logic [7:0]  draw_y_o,
  output logic [3:0]  draw_rows_o,
  output logic        unknown_opcode_o,
  output logic        stack_fault_o
);
  localparam int unsigned AW = $clog2(RamBytes);
  localparam int unsigned SW = $clog2(StackDepth + 1);
  localparam int unsigned SI = (StackDepth > 1) ? $clog2(StackDepth) : 1;

  logic [7:0]  v_q [16];
  logic [7:0]  v_d [16];
  logic [15:0] i_q, i_d;
  logic [11:0] pc_q, pc_d;
  logic [SW-1:0] sp_q, sp_d;
  logic [11:0] stk_q [StackDepth];
  logic [7:0]  dt_q, dt_d, st_q, st_d;
  logic        clr_q, clr_d, drw_q, drw_d, unk_q, unk_d, sf_q, sf_d;
  logic [7:0]  dx_q, dx_d, dy_q, dy_d;
  logic [3:0]  dn_q, dn_d;
  logic [15:0] op_q;
  logic        push, pop;
  logic [11:0] push_val;

  logic [3:0]  x, y, n;
  logic [7:0]  kk, vx, vy;
  logic [11:0] pc2;
  logic        pressed;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wd, ram_rd;

  assign x  = opcode_i[11:8];
  assign y  = opcode_i[7:4];
  assign n  = opcode_i[3:0];
  assign kk = opcode_i[7:0];
  assign vx = v_q[x];
  assign vy = v_q[y];
  assign pc2 = pc_q + 12'd2;
  assign pressed = vx[7:4] == 4'd0 && keys_pressed_i[vx[3:0]];

  // decode for the sequencer
  always_comb begin
    sts_o.x           = x;
    sts_o.is_load_act = action_i;
    sts_o.is_bcd      = opcode_i[15:12] == 4'hF && kk == 8'h33;
    sts_o.is_store    = opcode_i[15:12] == 4'hF && kk == 8'h55;
    sts_o.is_load     = opcode_i[15:12] == 4'hF && kk == 8'h65;
  end

  // bcd digits of vx for the latched opcode
  logic [7:0] bv;
  logic [3:0] hund, tens, ones;
  logic [7:0] rem1;
  assign bv = v_q[op_q[11:8]];
  always_comb begin
    hund = (bv >= 8'd200) ? 4'd2 : (bv >= 8'd100) ? 4'd1 : 4'd0;
    rem1 = bv - 8'(hund) * 8'd100;
    tens = 4'((16'(rem1) * 16'd205) >> 11);
    ones = 4'(rem1 - 8'(tens * 7'd10));
  end

  // ram port
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = AW'(i_q) + AW'(ctl_i.step);
    ram_wd   = v_q[ctl_i.step];
    case (ctl_i.cmd)
      CMD_FONT: begin
        ram_we = 1'b1; ram_addr = AW'(ctl_i.step) ;
        ram_wd = 8'h00;
      end
      CMD_LOAD: begin
        ram_we = 1'b1;
        ram_addr = AW'(ProgramStart) + AW'(load_offset_i);
        ram_wd = load_data_i;
      end
      CMD_BCD: begin
        ram_we = 1'b1;
        ram_wd = (ctl_i.step == 4'd0) ? {4'd0, hund} :
                 (ctl_i.step == 4'd1) ? {4'd0, tens} : {4'd0, ones};
      end
      CMD_STORE: ram_we = 1'b1;
      default: ;
    endcase
  end

  // font fill uses its own counter width
  logic [6:0] fcnt_q;
  logic          fwe;
  logic [AW-1:0] faddr;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fcnt_q <= '0;
    else if (ctl_i.cmd == CMD_FONT) fcnt_q <= fcnt_q + 7'd1;
  end
  assign fwe   = ctl_i.cmd == CMD_FONT;
  assign faddr = AW'(fcnt_q);

  c8x_ram #(.Width(8), .Depth(RamBytes)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (fwe ? faddr : ram_addr),
    .wdata_i(fwe ? font_byte(fcnt_q) : ram_wd),
    .rdata_o(ram_rd)
  );

  // execute step
  always_comb begin
    logic [8:0] sum;
    logic [7:0] r;
    logic [1:0] f;
    v_d = v_q;
    i_d = i_q; pc_d = pc_q; sp_d = sp_q; dt_d = dt_q; st_d = st_q;
    clr_d = clr_q; drw_d = drw_q; unk_d = unk_q; sf_d = sf_q;
    dx_d = dx_q; dy_d = dy_q; dn_d = dn_q;
    push = 1'b0; pop = 1'b0; push_val = pc2;
    sum = 9'd0; r = 8'd0; f = 2'd2;
    case (ctl_i.cmd)
      CMD_LOAD: begin
        pc_d = 12'(ProgramStart);
        clr_d = 1'b0; drw_d = 1'b0; unk_d = 1'b0; sf_d = 1'b0;
        dx_d = '0; dy_d = '0; dn_d = '0;
      end
      CMD_EXEC: begin
        clr_d = 1'b0; drw_d = 1'b0; unk_d = 1'b0; sf_d = 1'b0;
        dx_d = '0; dy_d = '0; dn_d = '0;
        pc_d = pc2;
        case (opcode_i[15:12])
          4'h0: begin
            if (opcode_i == 16'h00E0) clr_d = 1'b1;
            else if (opcode_i == 16'h00EE) begin
              if (sp_q >= SW'(StackDepth)) begin
                sf_d = 1'b1; pc_d = 12'd0;
              end else begin
                pc_d = stk_q[sp_q[SI-1:0]];
                pop = 1'b1;
                sp_d = sp_q + SW'(1);
              end
            end else unk_d = 1'b1;
          end
          4'h1: pc_d = opcode_i[11:0];
          4'h2: begin
            if (sp_q == '0) sf_d = 1'b1;
            else begin
              sp_d = sp_q - SW'(1);
              push = 1'b1;
            end
            pc_d = opcode_i[11:0];
          end
          4'h3: if (vx == kk) pc_d = pc_q + 12'd4;
          4'h4: if (vx != kk) pc_d = pc_q + 12'd4;
          4'h5: if (n != 4'd0) unk_d = 1'b1; else if (vx == vy) pc_d = pc_q + 12'd4;
          4'h6: v_d[x] = kk;
          4'h7: v_d[x] = vx + kk;
          4'h8: begin
            case (n)
              4'h0: r = vy;
              4'h1: r = vx | vy;
              4'h2: r = vx & vy;
              4'h3: r = vx ^ vy;
              4'h4: begin sum = {1'b0, vx} + {1'b0, vy}; r = sum[7:0]; f = {1'b0, sum[8]}; end
              4'h5: begin r = vx - vy; f = {1'b0, vx > vy}; end
              4'h6: begin r = vx >> 1; f = {1'b0, vx[0]}; end
              4'h7: begin r = vy - vx; f = {1'b0, vy > vx}; end
              4'hE: begin r = vx << 1; f = {1'b0, vx[7]}; end
              default: unk_d = 1'b1;
            endcase
            if (!unk_d) begin
              v_d[x] = r;
              if (f != 2'd2) v_d[15] = {7'd0, f[0]};
            end
          end
          4'h9: if (n != 4'd0) unk_d = 1'b1; else if (vx != vy) pc_d = pc_q + 12'd4;
          4'hA: i_d = {4'd0, opcode_i[11:0]};
          4'hB: pc_d = {4'd0, v_q[0]} + opcode_i[11:0];
          4'hC: v_d[x] = random_byte_i & kk;
          4'hD: begin drw_d = 1'b1; dx_d = vx; dy_d = vy; dn_d = n; end
          4'hE: begin
            if (kk == 8'h9E) begin if (pressed) pc_d = pc_q + 12'd4; end
            else if (kk == 8'hA1) begin if (!pressed) pc_d = pc_q + 12'd4; end
            else unk_d = 1'b1;
          end
          default: begin
            case (kk)
              8'h07: v_d[x] = dt_q;
              8'h0A, 8'h33, 8'h55, 8'h65: ;
              8'h15: dt_d = vx;
              8'h18: st_d = vx;
              8'h1E: i_d = i_q + {8'd0, vx};
              8'h29: i_d = {6'd0, vx, 2'b00} + {8'd0, vx};
              default: unk_d = 1'b1;
            endcase
          end
        endcase
      end
      CMD_LDDATA: v_d[ctl_i.step] = ram_rd;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd == CMD_EXEC) op_q <= opcode_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 16; k++) v_q[k] <= '0;
      for (int k = 0; k < StackDepth; k++) stk_q[k] <= '0;
      i_q <= '0; pc_q <= '0; sp_q <= SW'(StackDepth); dt_q <= '0; st_q <= '0;
      clr_q <= 1'b0; drw_q <= 1'b0; unk_q <= 1'b0; sf_q <= 1'b0;
      dx_q <= '0; dy_q <= '0; dn_q <= '0;
    end else begin
      v_q <= v_d;
      i_q <= i_d; pc_q <= pc_d; sp_q <= sp_d; dt_q <= dt_d; st_q <= st_d;
      clr_q <= clr_d; drw_q <= drw_d; unk_q <= unk_d; sf_q <= sf_d;
      dx_q <= dx_d; dy_q <= dy_d; dn_q <= dn_d;
      if (push) stk_q[sp_d[SI-1:0]] <= push_val;
      if (pop) stk_q[sp_q[SI-1:0]] <= '0;
    end
  end

  assign pc_value_o        = pc_q;
  assign index_value_o     = i_q;
  assign delay_value_o     = dt_q;
  assign sound_value_o     = st_q;
  assign clear_request_o   = clr_q;
  assign draw_request_o    = drw_q;
  assign draw_x_o          = dx_q;
  assign draw_y_o          = dy_q;
  assign draw_rows_o       = dn_q;
  assign unknown_opcode_o  = unk_q;
  assign stack_fault_o     = sf_q;
endmodule
